// ===== rtl/core/pmp_pkg.sv =====
// shared types, constants and the result microprogram for the mass properties block
`timescale 1ns / 1ps
`default_nettype none
package pmp_pkg;

  localparam int COORD_W        = 8;     // vertex coordinate field width
  localparam int COORD_BITS_DEF = 8;
  localparam int NUM_SUMS       = 10;
  localparam int SUM_W          = 64;
  localparam int ADD_W          = 45;    // widest per-triangle increment
  localparam int WIDE_W         = 152;   // numerator / quotient width
  localparam int DEN_W          = 73;    // divisor and remainder width
  localparam int FRAC_BITS      = 16;
  localparam int CENTER_W       = 24;
  localparam int INERTIA_W      = 63;
  localparam int MASS_W         = 62;
  localparam int NUM_RES        = 9;
  localparam int GEOM_STEPS     = 6;
  localparam int MUL_STEPS      = 64;
  localparam int DIV_STEPS      = WIDE_W;
  localparam int CNT_W          = 8;
  localparam int PC_W           = 5;
  localparam int IN_DATA_W      = 72;
  localparam int OUT_DATA_W     = 512;

  localparam logic [PC_W-1:0] PROG_LEN = 5'd30;

  // sum register indexes
  localparam logic [3:0] SUM_VOL  = 4'd0;
  localparam logic [3:0] SUM_X    = 4'd1;
  localparam logic [3:0] SUM_Y    = 4'd2;
  localparam logic [3:0] SUM_Z    = 4'd3;
  localparam logic [3:0] SUM_XX   = 4'd4;
  localparam logic [3:0] SUM_YY   = 4'd5;
  localparam logic [3:0] SUM_ZZ   = 4'd6;
  localparam logic [3:0] SUM_XY   = 4'd7;
  localparam logic [3:0] SUM_YZ   = 4'd8;
  localparam logic [3:0] SUM_ZX   = 4'd9;
  localparam logic [3:0] SUM_LAST = 4'd9;
  localparam logic [3:0] SEL_ONE  = 4'd15;

  // result slots
  localparam logic [3:0] RES_CX  = 4'd0;
  localparam logic [3:0] RES_CY  = 4'd1;
  localparam logic [3:0] RES_CZ  = 4'd2;
  localparam logic [3:0] RES_IXX = 4'd3;
  localparam logic [3:0] RES_IYY = 4'd4;
  localparam logic [3:0] RES_IZZ = 4'd5;
  localparam logic [3:0] RES_IXY = 4'd6;
  localparam logic [3:0] RES_IXZ = 4'd7;
  localparam logic [3:0] RES_IYZ = 4'd8;

  typedef enum logic [1:0] {
    OP_TERM,
    OP_DIV_CENTER,
    OP_DIV_INERTIA
  } op_e;

  typedef enum logic [2:0] {
    COEF_CENTER,
    COEF_P8,
    COEF_M5,
    COEF_P5,
    COEF_M4
  } coef_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GEOM,
    ST_ACCUM,
    ST_CHECK,
    ST_DISPATCH,
    ST_LOAD_A,
    ST_LOAD_B,
    ST_MUL,
    ST_DIV_LOAD,
    ST_DIV,
    ST_STORE,
    ST_WAIT_OUT
  } ctl_state_e;

  typedef struct packed {
    op_e        op;
    coef_e      coef;
    logic [3:0] sa;
    logic [3:0] sb;
    logic [3:0] dest;
  } prog_t;

  typedef struct packed {
    logic       load;
    logic       accum;
    logic       sum_clear;
    logic       acc_clear;
    logic       load_a;
    logic       load_b;
    logic [3:0] sel;
    coef_e      coef;
    logic       mul_step;
    logic       mul_last;
    logic       div_load;
    logic       div_step;
    logic       inertia;
    logic       store;
    logic [3:0] dest;
    logic       xfer;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic s0_bad;
    logic out_free;
  } status_t;

  // numerators: center = S*2^14, diagonal = 8 S0 (Sa+Sb) - 5 (Sc^2+Sd^2),
  // off-diagonal = 5 Sp Sq - 4 S0 Sr; each term is coef * sa * sb
  function automatic prog_t prog_op(input logic [PC_W-1:0] pc);
    prog_t r;
    r = '{OP_TERM, COEF_CENTER, SEL_ONE, SEL_ONE, RES_CX};
    case (pc)
      5'd0:  r = '{OP_TERM,        COEF_CENTER, SUM_X,   SEL_ONE, RES_CX};
      5'd1:  r = '{OP_DIV_CENTER,  COEF_CENTER, SEL_ONE, SEL_ONE, RES_CX};
      5'd2:  r = '{OP_TERM,        COEF_CENTER, SUM_Y,   SEL_ONE, RES_CY};
      5'd3:  r = '{OP_DIV_CENTER,  COEF_CENTER, SEL_ONE, SEL_ONE, RES_CY};
      5'd4:  r = '{OP_TERM,        COEF_CENTER, SUM_Z,   SEL_ONE, RES_CZ};
      5'd5:  r = '{OP_DIV_CENTER,  COEF_CENTER, SEL_ONE, SEL_ONE, RES_CZ};
      5'd6:  r = '{OP_TERM,        COEF_P8,     SUM_VOL, SUM_YY,  RES_IXX};
      5'd7:  r = '{OP_TERM,        COEF_P8,     SUM_VOL, SUM_ZZ,  RES_IXX};
      5'd8:  r = '{OP_TERM,        COEF_M5,     SUM_Y,   SUM_Y,   RES_IXX};
      5'd9:  r = '{OP_TERM,        COEF_M5,     SUM_Z,   SUM_Z,   RES_IXX};
      5'd10: r = '{OP_DIV_INERTIA, COEF_P8,     SEL_ONE, SEL_ONE, RES_IXX};
      5'd11: r = '{OP_TERM,        COEF_P8,     SUM_VOL, SUM_XX,  RES_IYY};
      5'd12: r = '{OP_TERM,        COEF_P8,     SUM_VOL, SUM_ZZ,  RES_IYY};
      5'd13: r = '{OP_TERM,        COEF_M5,     SUM_Z,   SUM_Z,   RES_IYY};
      5'd14: r = '{OP_TERM,        COEF_M5,     SUM_X,   SUM_X,   RES_IYY};
      5'd15: r = '{OP_DIV_INERTIA, COEF_P8,     SEL_ONE, SEL_ONE, RES_IYY};
      5'd16: r = '{OP_TERM,        COEF_P8,     SUM_VOL, SUM_XX,  RES_IZZ};
      5'd17: r = '{OP_TERM,        COEF_P8,     SUM_VOL, SUM_YY,  RES_IZZ};
      5'd18: r = '{OP_TERM,        COEF_M5,     SUM_X,   SUM_X,   RES_IZZ};
      5'd19: r = '{OP_TERM,        COEF_M5,     SUM_Y,   SUM_Y,   RES_IZZ};
      5'd20: r = '{OP_DIV_INERTIA, COEF_P8,     SEL_ONE, SEL_ONE, RES_IZZ};
      5'd21: r = '{OP_TERM,        COEF_P5,     SUM_X,   SUM_Y,   RES_IXY};
      5'd22: r = '{OP_TERM,        COEF_M4,     SUM_VOL, SUM_XY,  RES_IXY};
      5'd23: r = '{OP_DIV_INERTIA, COEF_P8,     SEL_ONE, SEL_ONE, RES_IXY};
      5'd24: r = '{OP_TERM,        COEF_P5,     SUM_Z,   SUM_X,   RES_IXZ};
      5'd25: r = '{OP_TERM,        COEF_M4,     SUM_VOL, SUM_ZX,  RES_IXZ};
      5'd26: r = '{OP_DIV_INERTIA, COEF_P8,     SEL_ONE, SEL_ONE, RES_IXZ};
      5'd27: r = '{OP_TERM,        COEF_P5,     SUM_Y,   SUM_Z,   RES_IYZ};
      5'd28: r = '{OP_TERM,        COEF_M4,     SUM_VOL, SUM_YZ,  RES_IYZ};
      5'd29: r = '{OP_DIV_INERTIA, COEF_P8,     SEL_ONE, SEL_ONE, RES_IYZ};
      default: r = '{OP_TERM, COEF_CENTER, SEL_ONE, SEL_ONE, RES_CX};
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/pmp_datapath.sv =====
// datapath: triangle integral stages, sum registers, serial multiplier, divider, result regs
`timescale 1ns / 1ps
`default_nettype none
module pmp_datapath #(
  parameter int COORD_BITS = pmp_pkg::COORD_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire pmp_pkg::cmd_t                       cmd_i,
  output pmp_pkg::status_t                         status_o,
  input  wire logic [pmp_pkg::IN_DATA_W-1:0]       in_data_i,
  input  wire logic                                in_last_i,
  output logic [pmp_pkg::OUT_DATA_W-1:0]           out_data_o,
  output logic                                     out_err_o,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i
);

  localparam int CW    = pmp_pkg::COORD_W;
  localparam int SHIFT = CW - COORD_BITS;
  localparam int SW    = pmp_pkg::SUM_W;
  localparam int AW    = pmp_pkg::ADD_W;
  localparam int WW    = pmp_pkg::WIDE_W;
  localparam int DW    = pmp_pkg::DEN_W;
  localparam int RW    = pmp_pkg::INERTIA_W;
  localparam int MW    = pmp_pkg::MASS_W;
  localparam int CNW   = pmp_pkg::CENTER_W;
  localparam int NEXT_AX [3] = '{1, 2, 0};

  // vertex coordinates, [axis][vertex]
  logic signed [CW-1:0]  p_q   [3][3];
  logic signed [8:0]     e1_q  [3];
  logic signed [8:0]     e2_q  [3];
  logic signed [8:0]     s01_q [3];
  logic signed [9:0]     f1_q  [3];
  logic signed [15:0]    q0_q  [3];
  logic signed [10:0]    fp_q  [3][3];
  logic signed [17:0]    n_q   [3];
  logic signed [17:0]    q1_q  [3];
  logic signed [22:0]    pq0_q [3];
  logic signed [17:0]    f2_q  [3];
  logic signed [23:0]    pq1_q [3];
  logic signed [26:0]    t2_q  [3];
  logic signed [19:0]    t3_q  [3][3];
  logic signed [27:0]    w_q   [3];
  logic signed [AW-1:0]  add_q [pmp_pkg::NUM_SUMS];
  logic                  last_q;

  logic [SW-1:0]         sum_q [pmp_pkg::NUM_SUMS];

  logic signed [WW-1:0]  mcand_q;
  logic [SW-1:0]         mplier_q;
  logic signed [WW-1:0]  acc_q;
  logic [WW-1:0]         dvd_q;
  logic [DW-1:0]         rem_q;
  logic [DW-1:0]         den_q;
  logic                  neg_q;
  logic [RW-1:0]         res_q [pmp_pkg::NUM_RES];

  logic [MW-1:0]         mass_q;
  logic [CNW-1:0]        cen_q [3];
  logic [RW-1:0]         ine_q [6];
  logic                  err_q;
  logic                  out_valid_q;

  logic [SW-1:0]         rd_sum;
  logic signed [WW-1:0]  rd_ext;
  logic signed [WW-1:0]  scaled;
  logic [WW-1:0]         mag;
  logic [DW-1:0]         s0_ext;
  logic [DW-1:0]         rem_sh;
  logic                  rem_ge;
  logic [WW-1:0]         lim;
  logic [WW-1:0]         q_sat;
  logic [WW-1:0]         q_val;
  logic                  s0_bad;

  function automatic logic signed [CW-1:0] coord(input logic [CW-1:0] raw);
    logic signed [CW-1:0] t;
    t = $signed(raw << SHIFT);
    return t >>> SHIFT;
  endfunction

  // triangle stages, free running off the held vertex registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int v = 0; v < 3; v++) begin
        for (int a = 0; a < 3; a++) begin
          p_q[a][v] <= coord(in_data_i[(v*3+a)*CW +: CW]);
        end
      end
      last_q <= in_last_i;
    end
    for (int a = 0; a < 3; a++) begin
      e1_q[a]  <= 9'(p_q[a][1] - p_q[a][0]);
      e2_q[a]  <= 9'(p_q[a][2] - p_q[a][0]);
      s01_q[a] <= 9'(p_q[a][0] + p_q[a][1]);
      f1_q[a]  <= 10'(p_q[a][0] + p_q[a][1] + p_q[a][2]);
      q0_q[a]  <= 16'(p_q[a][0] * p_q[a][0]);
      for (int k = 0; k < 3; k++) begin
        fp_q[a][k] <= 11'(p_q[a][0] + p_q[a][1] + p_q[a][2] + p_q[a][k]);
        t3_q[a][k] <= 20'(f2_q[a] + p_q[a][k] * fp_q[a][k]);
      end
      q1_q[a]  <= 18'(q0_q[a] + p_q[a][1] * s01_q[a]);
      pq0_q[a] <= 23'(p_q[a][0] * q0_q[a]);
      f2_q[a]  <= 18'(q1_q[a] + p_q[a][2] * f1_q[a]);
      pq1_q[a] <= 24'(p_q[a][1] * q1_q[a]);
      t2_q[a]  <= 27'(pq0_q[a] + pq1_q[a] + p_q[a][2] * f2_q[a]);
      w_q[a]   <= 28'(p_q[NEXT_AX[a]][0] * t3_q[a][0] + p_q[NEXT_AX[a]][1] * t3_q[a][1]
                    + p_q[NEXT_AX[a]][2] * t3_q[a][2]);
      add_q[1+a] <= AW'(n_q[a] * f2_q[a]);
      add_q[4+a] <= AW'(n_q[a] * t2_q[a]);
      add_q[7+a] <= AW'(n_q[a] * w_q[a]);
    end
    n_q[0]   <= 18'(e1_q[1] * e2_q[2] - e1_q[2] * e2_q[1]);
    n_q[1]   <= 18'(e1_q[2] * e2_q[0] - e1_q[0] * e2_q[2]);
    n_q[2]   <= 18'(e1_q[0] * e2_q[1] - e1_q[1] * e2_q[0]);
    add_q[0] <= AW'(n_q[0] * f1_q[0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < pmp_pkg::NUM_SUMS; i++) sum_q[i] <= '0;
    end else if (cmd_i.sum_clear) begin
      for (int i = 0; i < pmp_pkg::NUM_SUMS; i++) sum_q[i] <= '0;
    end else if (cmd_i.accum) begin
      for (int i = 0; i < pmp_pkg::NUM_SUMS; i++) sum_q[i] <= sum_q[i] + SW'(add_q[i]);
    end
  end

  // operand read and scaling
  always_comb begin
    rd_sum = (cmd_i.sel <= pmp_pkg::SUM_LAST) ? sum_q[cmd_i.sel] : '0;
    rd_ext = WW'($signed(rd_sum));
    case (cmd_i.coef)
      pmp_pkg::COEF_CENTER: scaled = rd_ext <<< 14;
      pmp_pkg::COEF_P8:     scaled = rd_ext <<< 3;
      pmp_pkg::COEF_M5:     scaled = -((rd_ext <<< 2) + rd_ext);
      pmp_pkg::COEF_P5:     scaled = (rd_ext <<< 2) + rd_ext;
      pmp_pkg::COEF_M4:     scaled = -(rd_ext <<< 2);
      default:              scaled = rd_ext;
    endcase
    mag    = acc_q[WW-1] ? WW'(-acc_q) : WW'(acc_q);
    s0_ext = DW'(sum_q[0]);
    rem_sh = {rem_q[DW-2:0], dvd_q[WW-1]};
    rem_ge = (rem_sh >= den_q);
    lim    = WW'(1) << (cmd_i.inertia ? RW - 1 : CNW - 1);
    if (neg_q) q_sat = (dvd_q > lim) ? lim : dvd_q;
    else       q_sat = (dvd_q > lim - WW'(1)) ? lim - WW'(1) : dvd_q;
    q_val  = neg_q ? -q_sat : q_sat;
    s0_bad = sum_q[0][SW-1] || (sum_q[0] == '0);
  end

  // bit-serial multiply, sign bit of the multiplier weighs negative
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_a) mcand_q <= scaled;
    if (cmd_i.load_b) mplier_q <= (cmd_i.sel == pmp_pkg::SEL_ONE) ? SW'(1) : rd_sum;
    if (cmd_i.acc_clear) begin
      acc_q <= '0;
    end else if (cmd_i.mul_step) begin
      if (mplier_q[0]) acc_q <= cmd_i.mul_last ? acc_q - mcand_q : acc_q + mcand_q;
    end
    if (cmd_i.mul_step) begin
      mcand_q  <= mcand_q <<< 1;
      mplier_q <= mplier_q >> 1;
    end
    // restoring divide of the magnitude, quotient shifts into the dividend
    if (cmd_i.div_load) begin
      neg_q <= acc_q[WW-1];
      dvd_q <= cmd_i.inertia ? (mag << pmp_pkg::FRAC_BITS) : mag;
      rem_q <= '0;
      den_q <= cmd_i.inertia ? ((s0_ext << 9) - (s0_ext << 5)) : s0_ext;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_ge ? rem_sh - den_q : rem_sh;
      dvd_q <= {dvd_q[WW-2:0], rem_ge};
    end
    if (cmd_i.store) res_q[cmd_i.dest] <= q_val[RW-1:0];
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.xfer) begin
      err_q  <= s0_bad;
      mass_q <= s0_bad ? '0
              : ((sum_q[0] > SW'({MW{1'b1}})) ? {MW{1'b1}} : sum_q[0][MW-1:0]);
      for (int i = 0; i < 3; i++) cen_q[i] <= s0_bad ? '0 : res_q[i][CNW-1:0];
      for (int i = 0; i < 6; i++) ine_q[i] <= s0_bad ? '0 : res_q[3+i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.xfer) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_data_o = {ine_q[5], ine_q[4], ine_q[3], ine_q[2], ine_q[1], ine_q[0],
                       cen_q[2], cen_q[1], cen_q[0], mass_q};
  assign out_err_o   = err_q;
  assign out_valid_o = out_valid_q;

  assign status_o.last     = last_q;
  assign status_o.s0_bad   = s0_bad;
  assign status_o.out_free = !out_valid_q || out_ready_i;

endmodule
`default_nettype wire

// ===== rtl/core/pmp_ctrl.sv =====
// controller: sequences triangle intake, accumulation and the result microprogram
`timescale 1ns / 1ps
`default_nettype none
module pmp_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire pmp_pkg::status_t  status_i,
  output pmp_pkg::cmd_t          cmd_o
);

  pmp_pkg::ctl_state_e              state_q, state_d;
  logic [pmp_pkg::CNT_W-1:0]        cnt_q, cnt_d;
  logic [pmp_pkg::PC_W-1:0]         pc_q, pc_d;
  pmp_pkg::prog_t                   op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pmp_pkg::ST_IDLE;
      cnt_q   <= '0;
      pc_q    <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pc_q    <= pc_d;
    end
  end

  always_comb begin
    op         = pmp_pkg::prog_op(pc_q);
    state_d    = state_q;
    cnt_d      = cnt_q;
    pc_d       = pc_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.sel  = op.sa;
    cmd_o.coef = op.coef;
    cmd_o.dest = op.dest;
    cmd_o.inertia = (op.op == pmp_pkg::OP_DIV_INERTIA);
    case (state_q)
      pmp_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = pmp_pkg::ST_GEOM;
        end
      end
      pmp_pkg::ST_GEOM: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == pmp_pkg::CNT_W'(pmp_pkg::GEOM_STEPS - 1)) state_d = pmp_pkg::ST_ACCUM;
      end
      pmp_pkg::ST_ACCUM: begin
        cmd_o.accum = 1'b1;
        state_d     = status_i.last ? pmp_pkg::ST_CHECK : pmp_pkg::ST_IDLE;
      end
      pmp_pkg::ST_CHECK: begin
        cmd_o.acc_clear = 1'b1;
        pc_d            = '0;
        state_d = status_i.s0_bad ? pmp_pkg::ST_WAIT_OUT : pmp_pkg::ST_DISPATCH;
      end
      pmp_pkg::ST_DISPATCH: begin
        if (pc_q == pmp_pkg::PROG_LEN)        state_d = pmp_pkg::ST_WAIT_OUT;
        else if (op.op == pmp_pkg::OP_TERM)   state_d = pmp_pkg::ST_LOAD_A;
        else                                  state_d = pmp_pkg::ST_DIV_LOAD;
      end
      pmp_pkg::ST_LOAD_A: begin
        cmd_o.load_a = 1'b1;
        state_d      = pmp_pkg::ST_LOAD_B;
      end
      pmp_pkg::ST_LOAD_B: begin
        cmd_o.load_b = 1'b1;
        cmd_o.sel    = op.sb;
        cnt_d        = '0;
        state_d      = pmp_pkg::ST_MUL;
      end
      pmp_pkg::ST_MUL: begin
        cmd_o.mul_step = 1'b1;
        cmd_o.mul_last = (cnt_q == pmp_pkg::CNT_W'(pmp_pkg::MUL_STEPS - 1));
        cnt_d          = cnt_q + 1'b1;
        if (cmd_o.mul_last) begin
          pc_d    = pc_q + 1'b1;
          state_d = pmp_pkg::ST_DISPATCH;
        end
      end
      pmp_pkg::ST_DIV_LOAD: begin
        cmd_o.div_load = 1'b1;
        cnt_d          = '0;
        state_d        = pmp_pkg::ST_DIV;
      end
      pmp_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == pmp_pkg::CNT_W'(pmp_pkg::DIV_STEPS - 1)) state_d = pmp_pkg::ST_STORE;
      end
      pmp_pkg::ST_STORE: begin
        cmd_o.store     = 1'b1;
        cmd_o.acc_clear = 1'b1;
        pc_d            = pc_q + 1'b1;
        state_d         = pmp_pkg::ST_DISPATCH;
      end
      pmp_pkg::ST_WAIT_OUT: begin
        if (status_i.out_free) begin
          cmd_o.xfer      = 1'b1;
          cmd_o.sum_clear = 1'b1;
          state_d         = pmp_pkg::ST_IDLE;
        end
      end
      default: state_d = pmp_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/polyhedron_mass_properties.sv =====
// top level: mass, center of mass and inertia of a closed triangle mesh
`timescale 1ns / 1ps
`default_nettype none
//
//  channel   dir  width      contents
//  s_axis    in   72 + last  one triangle per transaction, tlast on the final face
//  m_axis    out  512 + user one result per mesh, tuser flags a non-positive volume
//
//  a triangle is taken in on the accepting edge, passes through the integral
//  stages and then has its ten increments added into the sums
//  after the final face the result is formed by one shared bit-serial multiplier
//  (21 products) and one restoring divider (9 quotients); a non-positive volume
//  skips this
//  reset clears the sums and control; the result waits in the output register,
//  and the next mesh is taken in while it waits, up to its own final face
//
module polyhedron_mass_properties #(
  parameter int COORD_BITS = pmp_pkg::COORD_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z (8 bits each, lowest first)
  input  wire logic [pmp_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // final_face
  input  wire logic                              s_axis_tlast,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // mass_times_six(62), center_x/y/z(24 each), inertia_xx, yy, zz, xy, xz, yz(63 each)
  output logic [pmp_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
  // open_mesh_error
  output logic [0:0]                             m_axis_tuser
);

  pmp_pkg::cmd_t    cmd;
  pmp_pkg::status_t status;

  // sequencing: intake, accumulate, then the result microprogram
  pmp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // arithmetic, sums and the output register
  pmp_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .out_data_o  (m_axis_tdata),
    .out_err_o   (m_axis_tuser[0]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready)
  );

endmodule
`default_nettype wire

// ===== rtl/core/pmp_checker.sv =====
// port-level checks for the mass properties block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module pmp_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           s_axis_tvalid,
  input wire logic                           s_axis_tready,
  input wire logic                           m_axis_tvalid,
  input wire logic                           m_axis_tready,
  input wire logic [pmp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic [0:0]                     m_axis_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // error result carries all-zero fields
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("error result with nonzero fields");

  // a good result has a positive volume
  a_mass_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[pmp_pkg::MASS_W-1:0] != '0)
    else $error("good result with zero volume");

  // triangle intake is busy the cycle after a transaction
  a_intake_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("back-to-back triangle transactions");

endmodule

bind polyhedron_mass_properties pmp_checker u_pmp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

// ===== verif/testbench.sv =====
// self-checking testbench for the polyhedron mass properties block
`timescale 1ns / 1ps
module testbench;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int DRAIN_CYCLES   = 3500;
  localparam int LONG_HOLD      = 9000;
  localparam int RANDOM_ITEMS   = 600;

  // vertex triple, packed so that a_x lands in the lowest byte of tdata
  typedef struct packed {
    logic signed [7:0] cz, cy, cx, bz, by, bx, az, ay, ax;
  } tri_t;

  typedef struct packed {
    tri_t face;
    logic last;
    logic want_err; // result typed in: open mesh error, all fields zero
  } row_t;

  typedef struct {
    logic [pmp_pkg::OUT_DATA_W-1:0] data;
    logic                           err;
  } mesh_result_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [pmp_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                           s_axis_tlast = 1'b0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [pmp_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic [0:0]                     m_axis_tuser;
  logic                           row_want_err = 1'b0;

  logic [63:0]  vol_sums [pmp_pkg::NUM_SUMS];
  mesh_result_t pending_results [$];
  row_t         dir_tab [17];
  int           n_fail = 0, n_tri = 0, n_mesh = 0, n_err_mesh = 0, n_out = 0;
  int           idle_cycles = 0;

  polyhedron_mass_properties dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // per-axis sums of products of the three vertex coordinates
  function automatic void axis_poly(input longint p0, p1, p2, output longint t [6]);
    longint s01, q0, q1;
    s01  = p0 + p1;
    t[0] = s01 + p2;
    q0   = p0 * p0;
    q1   = q0 + p1 * s01;
    t[1] = q1 + p2 * t[0];
    t[2] = p0 * q0 + p1 * q1 + p2 * t[1];
    t[3] = t[1] + p0 * (t[0] + p0);
    t[4] = t[1] + p1 * (t[0] + p1);
    t[5] = t[1] + p2 * (t[0] + p2);
  endfunction

  function automatic longint face_volume(tri_t t);
    longint nx;
    nx = (longint'(t.by) - t.ay) * (longint'(t.cz) - t.az)
       - (longint'(t.bz) - t.az) * (longint'(t.cy) - t.ay);
    return nx * (longint'(t.ax) + t.bx + t.cx);
  endfunction

  function automatic void add_face(tri_t t);
    longint tx [6], ty [6], tz [6];
    longint e1x, e1y, e1z, e2x, e2y, e2z, nx, ny, nz;
    longint inc [pmp_pkg::NUM_SUMS];
    e1x = longint'(t.bx) - t.ax; e1y = longint'(t.by) - t.ay; e1z = longint'(t.bz) - t.az;
    e2x = longint'(t.cx) - t.ax; e2y = longint'(t.cy) - t.ay; e2z = longint'(t.cz) - t.az;
    nx = e1y * e2z - e1z * e2y;
    ny = e1z * e2x - e1x * e2z;
    nz = e1x * e2y - e1y * e2x;
    axis_poly(t.ax, t.bx, t.cx, tx);
    axis_poly(t.ay, t.by, t.cy, ty);
    axis_poly(t.az, t.bz, t.cz, tz);
    inc[0] = nx * tx[0];
    inc[1] = nx * tx[1];
    inc[2] = ny * ty[1];
    inc[3] = nz * tz[1];
    inc[4] = nx * tx[2];
    inc[5] = ny * ty[2];
    inc[6] = nz * tz[2];
    inc[7] = nx * (t.ay * tx[3] + t.by * tx[4] + t.cy * tx[5]);
    inc[8] = ny * (t.az * ty[3] + t.bz * ty[4] + t.cz * ty[5]);
    inc[9] = nz * (t.ax * tz[3] + t.bx * tz[4] + t.cx * tz[5]);
    for (int i = 0; i < pmp_pkg::NUM_SUMS; i++) vol_sums[i] += inc[i];
  endfunction

  // truncating signed division, saturated to a signed field of w bits
  function automatic logic [63:0] fix_quot(logic signed [191:0] num, logic [191:0] den, int w);
    logic [191:0] mag, q;
    logic [63:0]  lim, qv;
    logic         big;
    mag = num[191] ? -num : num;
    q   = mag / den;
    lim = 64'd1 << (w - 1);
    big = |q[191:64];
    qv  = q[63:0];
    if (num[191]) begin
      if (big || qv > lim) qv = lim;
      qv = -qv;
    end else if (big || qv > lim - 1) begin
      qv = lim - 1;
    end
    return qv & ((lim << 1) - 1);
  endfunction

  // mass, center and inertia from the sums, then the sums clear
  function automatic mesh_result_t mesh_properties();
    mesh_result_t r;
    logic signed [191:0] sv [pmp_pkg::NUM_SUMS];
    logic signed [191:0] den, num;
    logic [63:0]         iner [6];
    logic [63:0]         cq;
    int                  dg [3][4];
    int                  od [3][3];
    r.data = '0;
    r.err  = 1'b0;
    dg = '{'{5, 6, 2, 3}, '{4, 6, 3, 1}, '{4, 5, 1, 2}};
    od = '{'{1, 2, 7}, '{3, 1, 9}, '{2, 3, 8}};
    for (int i = 0; i < pmp_pkg::NUM_SUMS; i++) sv[i] = {{128{vol_sums[i][63]}}, vol_sums[i]};
    if (vol_sums[0][63] || vol_sums[0] == 0) begin
      r.err = 1'b1;
    end else begin
      den = sv[0] * 480;
      r.data[61:0] = vol_sums[0] > 64'h3FFF_FFFF_FFFF_FFFF ? '1 : vol_sums[0][61:0];
      for (int i = 0; i < 3; i++) begin
        cq = fix_quot(sv[1+i] * 16384, sv[0], pmp_pkg::CENTER_W);
        r.data[62 + 24*i +: 24] = cq[23:0];
      end
      for (int i = 0; i < 3; i++) begin
        num = sv[0] * 8 * (sv[dg[i][0]] + sv[dg[i][1]])
            - (sv[dg[i][2]] * sv[dg[i][2]] + sv[dg[i][3]] * sv[dg[i][3]]) * 5;
        iner[i] = fix_quot(num * 65536, den, pmp_pkg::INERTIA_W);
        num = sv[od[i][0]] * sv[od[i][1]] * 5 - sv[0] * 4 * sv[od[i][2]];
        iner[3+i] = fix_quot(num * 65536, den, pmp_pkg::INERTIA_W);
      end
      for (int i = 0; i < 6; i++) r.data[134 + 63*i +: 63] = iner[i][62:0];
    end
    for (int i = 0; i < pmp_pkg::NUM_SUMS; i++) vol_sums[i] = '0;
    return r;
  endfunction

  // input side: every accepted triangle updates the sums, a final face predicts a result
  always @(posedge clk_i) begin
    mesh_result_t r;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      add_face(tri_t'(s_axis_tdata));
      n_tri++;
      if (s_axis_tlast) begin
        r = mesh_properties();
        if (row_want_err) begin
          r.data = '0;
          r.err  = 1'b1;
        end
        n_mesh++;
        if (r.err) n_err_mesh++;
        pending_results.push_back(r);
      end
    end
  end

  // output side: compare each result transaction field by field
  always @(posedge clk_i) begin
    mesh_result_t exp_r;
    int           lsb [10];
    int           wid [10];
    string        nm [10];
    logic [pmp_pkg::OUT_DATA_W-1:0] msk, e_f, a_f;
    nm  = '{"mass_times_six", "center_x", "center_y", "center_z", "inertia_xx",
            "inertia_yy", "inertia_zz", "inertia_xy", "inertia_xz", "inertia_yz"};
    wid = '{62, 24, 24, 24, 63, 63, 63, 63, 63, 63};
    lsb[0] = 0;
    for (int k = 1; k < 10; k++) lsb[k] = lsb[k-1] + wid[k-1];
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_out++;
      if (pending_results.size() == 0) begin
        $display("%0t: result transaction expected none actual %h", $time, m_axis_tdata);
        n_fail++;
      end else begin
        exp_r = pending_results.pop_front();
        for (int k = 0; k < 10; k++) begin
          msk = (512'd1 << wid[k]) - 1;
          e_f = (exp_r.data >> lsb[k]) & msk;
          a_f = (m_axis_tdata >> lsb[k]) & msk;
          if (e_f !== a_f) begin
            $display("%0t: %s expected %h actual %h", $time, nm[k], e_f, a_f);
            n_fail++;
          end
        end
        if (exp_r.err !== m_axis_tuser[0]) begin
          $display("%0t: open_mesh_error expected %b actual %b", $time, exp_r.err,
                   m_axis_tuser[0]);
          n_fail++;
        end
      end
    end
  end

  // no transaction on either side for too long ends the run
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no transaction for %0d cycles", $time, idle_cycles);
      $display("status: fail");
      $finish;
    end
  end

  // receiver: stall modes change at random, one long hold-off
  initial begin
    int  mode;
    bit  held;
    held = 1'b0;
    mode = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held && n_tri >= 250) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end
      if ($urandom_range(0, 49) == 0) mode = $urandom_range(0, 2);
      case (mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        default: m_axis_tready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  function automatic row_t mk_row(int ax, ay, az, bx, by, bz, cx, cy, cz, bit last, bit err);
    row_t r;
    r.face = '{cz: 8'(cz), cy: 8'(cy), cx: 8'(cx), bz: 8'(bz), by: 8'(by), bx: 8'(bx),
               az: 8'(az), ay: 8'(ay), ax: 8'(ax)};
    r.last = last;
    r.want_err = err;
    return r;
  endfunction

  task automatic send_face(tri_t t, bit last, bit want_err);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= t;
    s_axis_tlast  <= last;
    row_want_err  <= want_err;
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
  endtask

  int burst_left = 0;

  // sender pacing: bursts of random length, random gaps in between
  task automatic paced_send(tri_t t, bit last);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    send_face(t, last, 1'b0);
  endtask

  function automatic logic signed [7:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return -8'sd128;
      1: return 8'sd127;
      2: return 8'($urandom_range(0, 7)) - 8'sd4;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    tri_t faces [$];
    tri_t t;
    logic signed [7:0] p [4][3];
    longint vol;
    int     n_tet;
    // collapsed triangle at the origin, then the unit tetrahedron, outward winding
    dir_tab = '{
      mk_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1),
      mk_row(0, 0, 0, 0, 1, 0, 1, 0, 0, 0, 0),
      mk_row(0, 0, 0, 1, 0, 0, 0, 0, 1, 0, 0),
      mk_row(0, 0, 0, 0, 0, 1, 0, 1, 0, 0, 0),
      mk_row(1, 0, 0, 0, 1, 0, 0, 0, 1, 1, 0),
      // same tetrahedron turned inside out: negative volume
      mk_row(0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0),
      mk_row(0, 0, 0, 0, 0, 1, 1, 0, 0, 0, 0),
      mk_row(0, 0, 0, 0, 1, 0, 0, 0, 1, 0, 0),
      mk_row(1, 0, 0, 0, 0, 1, 0, 1, 0, 1, 1),
      // corner tetrahedron spanning the full coordinate range
      mk_row(-128, -128, -128, -128, 127, -128, 127, -128, -128, 0, 0),
      mk_row(-128, -128, -128, 127, -128, -128, -128, -128, 127, 0, 0),
      mk_row(-128, -128, -128, -128, -128, 127, -128, 127, -128, 0, 0),
      mk_row(127, -128, -128, -128, 127, -128, -128, -128, 127, 1, 0),
      // collapsed triangles at the extremes
      mk_row(127, 127, 127, 127, 127, 127, 127, 127, 127, 1, 1),
      mk_row(-128, -128, -128, -128, -128, -128, -128, -128, -128, 1, 1),
      // flat square: zero volume
      mk_row(-128, -128, 0, 127, -128, 0, 127, 127, 0, 0, 1),
      mk_row(-128, -128, 0, 127, 127, 0, -128, 127, 0, 1, 1)
    };
    for (int i = 0; i < pmp_pkg::NUM_SUMS; i++) vol_sums[i] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) send_face(dir_tab[i].face, dir_tab[i].last, dir_tab[i].want_err);
    s_axis_tvalid <= 1'b0;

    while (n_tri < RANDOM_ITEMS + 17) begin
      faces.delete();
      if ($urandom_range(0, 9) < 7) begin
        // one to three tetrahedra, each wound outward
        n_tet = $urandom_range(1, 3);
        repeat (n_tet) begin
          foreach (p[i, j]) p[i][j] = rnd_coord();
          t = '{cz: p[1][2], cy: p[1][1], cx: p[1][0], bz: p[2][2], by: p[2][1],
                bx: p[2][0], az: p[0][2], ay: p[0][1], ax: p[0][0]};
          faces.push_back(t);
          t = '{cz: p[3][2], cy: p[3][1], cx: p[3][0], bz: p[1][2], by: p[1][1],
                bx: p[1][0], az: p[0][2], ay: p[0][1], ax: p[0][0]};
          faces.push_back(t);
          t = '{cz: p[2][2], cy: p[2][1], cx: p[2][0], bz: p[3][2], by: p[3][1],
                bx: p[3][0], az: p[0][2], ay: p[0][1], ax: p[0][0]};
          faces.push_back(t);
          t = '{cz: p[3][2], cy: p[3][1], cx: p[3][0], bz: p[2][2], by: p[2][1],
                bx: p[2][0], az: p[1][2], ay: p[1][1], ax: p[1][0]};
          faces.push_back(t);
          vol = 0;
          for (int k = faces.size() - 4; k < faces.size(); k++) vol += face_volume(faces[k]);
          // inward winding: swap the last two vertices of every face
          if (vol < 0) begin
            for (int k = faces.size() - 4; k < faces.size(); k++) begin
              t = faces[k];
              faces[k].bx = t.cx; faces[k].by = t.cy; faces[k].bz = t.cz;
              faces[k].cx = t.bx; faces[k].cy = t.by; faces[k].cz = t.bz;
            end
          end
        end
      end else begin
        // loose triangles, volume of either sign
        repeat ($urandom_range(1, 5)) begin
          t = 72'({$urandom(), $urandom(), $urandom()});
          faces.push_back(t);
        end
      end
      foreach (faces[k]) paced_send(faces[k], k == faces.size() - 1);
    end
    s_axis_tvalid <= 1'b0;
    s_axis_tlast  <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d triangles in %0d meshes, %0d of them with non-positive volume",
             n_tri, n_mesh, n_err_mesh);
    $display("%0d result transactions checked, %0d mismatches", n_out, n_fail);
    if (n_fail == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== polyhedron_mass_properties.f =====
rtl/core/pmp_pkg.sv
rtl/core/pmp_datapath.sv
rtl/core/pmp_ctrl.sv
rtl/core/polyhedron_mass_properties.sv
rtl/core/pmp_checker.sv
verif/testbench.sv
